/* src/smsr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smsr_pkg
// Shared types, constants and the generator step for the shuffled
// minimal-standard generator.
// ----------------------------------------------------------------------------
package smsr_pkg;

   localparam int VALUE_W = 31;
   localparam int WARMUP  = 8;

   localparam logic [14:0]        LCG_MUL = 15'd16807;
   localparam logic [VALUE_W-1:0] LCG_MOD = 31'h7FFF_FFFF;

   // controller -> datapath
   typedef struct packed {
      logic init_load;     // load generator with starting seed, arm step counter
      logic init_use_seed; // 1: seed register, 0: constant one
      logic init_step;     // one initialization step, fills table tail
      logic init_finish;   // previous output <- final initialization value
      logic tbl_read;      // read table at computed slot
      logic lcg_step;      // advance generator for the draw
      logic commit;        // swap table entry, load result register
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_init;     // previous output is zero: never initialized
      logic cnt_zero;      // initialization step counter has run out
   } dp_status_type;

   // x * 16807 mod (2^31 - 1), folded with the Mersenne identity
   function automatic logic [VALUE_W-1:0] lcg_next(input logic [VALUE_W-1:0] x);
      logic [45:0] prod;
      logic [31:0] sum;
      prod = 46'(x) * 46'(LCG_MUL);
      sum  = 32'(prod[45:31]) + 32'(prod[30:0]);
      if (sum >= 32'(LCG_MOD)) begin
         sum = sum - 32'(LCG_MOD);
      end
      return sum[VALUE_W-1:0];
   endfunction

endpackage

/* src/smsr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smsr_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module smsr_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/smsr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smsr_ctrl
// Sequencer: initialization, table read and result commit.
// ----------------------------------------------------------------------------
module smsr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_restart,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  smsr_pkg::dp_status_type status,
   output smsr_pkg::ctrl_cmd_type  cmd
);
   import smsr_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_INIT   = 2'd1;
   localparam logic [1:0] S_READ   = 2'd2;
   localparam logic [1:0] S_COMMIT = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_restart) begin
                  cmd.init_load     = 1'b1;
                  cmd.init_use_seed = 1'b1;
                  state_in          = S_INIT;
               end else if (status.need_init) begin
                  cmd.init_load = 1'b1;
                  state_in      = S_INIT;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_INIT: begin
            cmd.init_step = 1'b1;
            if (status.cnt_zero) begin
               cmd.init_finish = 1'b1;
               state_in        = S_READ;
            end
         end
         S_READ: begin
            cmd.tbl_read = 1'b1;
            cmd.lcg_step = 1'b1;
            state_in     = S_COMMIT;
         end
         S_COMMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* src/smsr_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smsr_dpath
// Generator register, seed register, slot decode, shuffle table and
// result register.
// ----------------------------------------------------------------------------
module smsr_dpath #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [smsr_pkg::VALUE_W-1:0]  csr_wdata,
   input  smsr_pkg::ctrl_cmd_type        cmd,
   output smsr_pkg::dp_status_type       status,
   output logic [smsr_pkg::VALUE_W-1:0]  rsp_value
);
   import smsr_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + WARMUP);
   localparam logic [CW-1:0] INIT_LAST = CW'(TABLE_DEPTH + WARMUP - 1);
   localparam logic [63:0]   SLOT_DIV  =
      64'd1 + (64'(LCG_MOD) - 64'd1) / 64'(TABLE_DEPTH);

   logic [VALUE_W-1:0] seed_ff, seed_in;
   logic [VALUE_W-1:0] lcg_ff, lcg_in;
   logic [VALUE_W-1:0] last_ff, last_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [VALUE_W-1:0] out_ff, out_in;

   logic [VALUE_W-1:0] seed_eff;
   logic [VALUE_W-1:0] lcg_step_val;
   logic [TABLE_DEPTH:1] above;
   logic [AW-1:0]      slot;
   logic               tbl_we;
   logic [AW-1:0]      tbl_waddr;
   logic [VALUE_W-1:0] tbl_wdata;
   logic [VALUE_W-1:0] tbl_rdata;

   // zero and the modulus itself both fold to one
   assign seed_eff = ((seed_ff == '0) || (seed_ff == LCG_MOD)) ? VALUE_W'(1) : seed_ff;
   assign lcg_step_val = lcg_next(lcg_ff);

   assign seed_in = csr_we ? csr_wdata : seed_ff;

   always_comb begin
      lcg_in = lcg_ff;
      if (cmd.init_load) begin
         lcg_in = cmd.init_use_seed ? seed_eff : VALUE_W'(1);
      end else if (cmd.init_step || cmd.lcg_step) begin
         lcg_in = lcg_step_val;
      end
   end

   always_comb begin
      last_in = last_ff;
      if (cmd.init_finish) begin
         last_in = lcg_step_val;
      end else if (cmd.commit) begin
         last_in = tbl_rdata;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.init_load) begin
         cnt_in = INIT_LAST;
      end else if (cmd.init_step) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   // slot = previous output / stride, clamped to the last slot: compare
   // against every stride multiple in parallel, the top one passed wins
   always_comb begin
      above = '0;
      for (int k = 1; k < TABLE_DEPTH; k++) begin
         above[k] = (64'(last_ff) >= 64'(k) * SLOT_DIV);
      end
   end

   always_comb begin
      slot = '0;
      for (int k = 1; k < TABLE_DEPTH; k++) begin
         if (above[k] && !above[k+1]) begin
            slot = slot | AW'(k);
         end
      end
   end

   always_comb begin
      if (cmd.commit) begin
         tbl_we    = 1'b1;
         tbl_waddr = slot;
         tbl_wdata = lcg_ff;
      end else begin
         tbl_we    = cmd.init_step && (cnt_ff < CW'(TABLE_DEPTH));
         tbl_waddr = cnt_ff[AW-1:0];
         tbl_wdata = lcg_step_val;
      end
   end

   assign out_in = cmd.commit ? tbl_rdata : out_ff;

   smsr_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_en   (cmd.tbl_read),
      .rd_addr (slot),
      .rd_data (tbl_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= VALUE_W'(1);
         last_ff <= '0;
         lcg_ff  <= '0;
         cnt_ff  <= '0;
      end else begin
         seed_ff <= seed_in;
         last_ff <= last_in;
         lcg_ff  <= lcg_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign status.need_init = (last_ff == '0);
   assign status.cnt_zero  = (cnt_ff == '0);
   assign rsp_value        = out_ff;

endmodule

/* src/shuffled_minimal_standard_rng.sv */
`timescale 1ns / 1ps
// Plain draw: one table read, then the commit into the result register; the
//   commit waits while an earlier result is still held and not yet taken.
// Init draw (first after reset, or restart): TABLE_DEPTH + 8 generator steps first.
// A new request is taken only after the previous item commits; the result
//   register lets the next item start while a result waits.
// Reset (synchronous, active high): seed = 1, table marked uninitialized.
// ----------------------------------------------------------------------------
// shuffled_minimal_standard_rng
// Park-Miller minimal-standard generator behind a Bays-Durham shuffle table.
// ----------------------------------------------------------------------------
module shuffled_minimal_standard_rng #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   // draw requests
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_restart,
   // results
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [smsr_pkg::VALUE_W-1:0] rsp_value,
   // seed register write
   input  logic                         csr_we,
   input  logic [smsr_pkg::VALUE_W-1:0] csr_wdata
);
   import smsr_pkg::*;

   // Controller sequences each item:
   //   idle -> (init: TABLE_DEPTH+8 generator steps, last TABLE_DEPTH fill
   //   the table from the top slot down) -> table read -> commit (swap
   //   slot, load result).
   // The generator step is an exact constant multiply folded mod 2^31-1.
   ctrl_cmd_type  cmd;
   dp_status_type status;

   smsr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_restart (req_restart),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .status      (status),
      .cmd         (cmd)
   );

   // Datapath: seed register is writable at any time; the slot is the
   // previous output divided by the table stride, clamped to the last slot.
   smsr_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_value (rsp_value)
   );

endmodule

/* src/smsr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smsr_checker
// Port-level checks for the shuffled minimal-standard generator.
// ----------------------------------------------------------------------------
module smsr_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [smsr_pkg::VALUE_W-1:0] rsp_value
);
   import smsr_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
      else $error("result changed while stalled");

   // generator never yields zero
   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_value != '0)
      else $error("zero result");

   // nor the modulus
   a_below_mod: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_value != LCG_MOD)
      else $error("result equals modulus");

   // one item at a time: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted back to back");

endmodule

bind shuffled_minimal_standard_rng smsr_checker u_chk (.*);
